// ===== design/skset_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skset_pkg
// Shared types, widths and codes of the sorted key set unit.
// ----------------------------------------------------------------------------
package skset_pkg;

  // store geometry
  localparam int SLOT_COUNT = 64;
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // fixed field widths of the channels
  localparam int OP_W   = 3;
  localparam int KEY_W  = 32;
  localparam int RIDX_W = 6;

  typedef logic [KEY_BITS-1:0] skey_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_LOWER  = 3'd2,
    OP_UPPER  = 3'd3,
    OP_FIRST  = 3'd4,
    OP_LAST   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  // per-cell update control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // what the encoder reports about the chain
  typedef struct packed {
    logic             bnd_hit;
    logic             bnd_eq;
    logic [IDX_W-1:0] pos;
    skey_t            bnd_key;
    skey_t            last_key;
  } enc_res_t;

  // map a key to a value whose unsigned order is the selected order
  function automatic skey_t order_key(input skey_t k, input logic sgn);
    skey_t flip;
    flip               = '0;
    flip[KEY_BITS-1]   = sgn;
    return k ^ flip;
  endfunction

endpackage
`default_nettype wire

// ===== design/skset_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skset_in_if
// Request channel: opcode and key with valid/ready handshake.
// ----------------------------------------------------------------------------
interface skset_in_if
  import skset_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface
`default_nettype wire

// ===== design/skset_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skset_out_if
// Result channel: hit flag, element key and position, insert flags.
// ----------------------------------------------------------------------------
interface skset_out_if
  import skset_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [KEY_W-1:0]  result_key;
  logic [RIDX_W-1:0] result_index;
  logic              was_present;
  logic              store_full;

  modport source (output valid, output hit, output result_key, output result_index,
                  output was_present, output store_full, input ready);
  modport sink   (input valid, input hit, input result_key, input result_index,
                  input was_present, input store_full, output ready);
endinterface
`default_nettype wire

// ===== design/skset_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skset_cell
// One slot of the sorted chain: holds a key, compares it with the search
// key every cycle and takes its left neighbour's key on an insert shift.
// ----------------------------------------------------------------------------
module skset_cell
  import skset_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire skey_t     nbr_key,
  input  wire skey_t     new_key,
  input  wire skey_t     cmp_ord,
  input  wire logic      signed_order,
  output      skey_t     key_o,
  output      logic      lt_o,
  output      logic      eq_o
);

  skey_t key_r;
  skey_t key_nxt;
  skey_t own_ord;
  logic  lt_r;
  logic  eq_r;

  // slot contents: load new key, shift from neighbour or hold
  always_comb begin
    priority if (ctl.load) begin
      key_nxt = new_key;
    end else if (ctl.shift) begin
      key_nxt = nbr_key;
    end else begin
      key_nxt = key_r;
    end
  end

  assign own_ord = order_key(key_r, signed_order);

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= (own_ord < cmp_ord);
    eq_r  <= (own_ord == cmp_ord);
  end

  assign key_o = key_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule
`default_nettype wire

// ===== design/skset_enc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skset_enc
// Finds the insertion boundary in the chain's compare flags, encodes its
// position and selects the boundary key and the last stored key.
// ----------------------------------------------------------------------------
module skset_enc
  import skset_pkg::*;
(
  input  wire logic [SLOT_COUNT-1:0] occ,
  input  wire logic [SLOT_COUNT-1:0] below,
  input  wire logic [SLOT_COUNT-1:0] eq,
  input  wire skey_t [SLOT_COUNT-1:0] keys,
  output      logic [SLOT_COUNT-1:0] bnd,
  output      enc_res_t              res
);

  logic [SLOT_COUNT-1:0] lst;

  // boundary: first slot not below the search key
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i == 0) begin
        bnd[i] = ~below[i];
      end else begin
        bnd[i] = below[i-1] & ~below[i];
      end
    end
  end

  // last occupied slot
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i == SLOT_COUNT - 1) begin
        lst[i] = occ[i];
      end else begin
        lst[i] = occ[i] & ~occ[i+1];
      end
    end
  end

  // one-hot encode and and-or selection
  always_comb begin
    res = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      res.bnd_hit  = res.bnd_hit | (bnd[i] & occ[i]);
      res.bnd_eq   = res.bnd_eq | (bnd[i] & occ[i] & eq[i]);
      res.pos      = res.pos | (bnd[i] ? IDX_W'(i) : '0);
      res.bnd_key  = res.bnd_key | (bnd[i] ? keys[i] : '0);
      res.last_key = res.last_key | (lst[i] ? keys[i] : '0);
    end
  end

endmodule
`default_nettype wire

// ===== design/sorted_key_set_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_set_unit
// Bounded set of distinct keys kept in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  in_chan   in   valid/ready    opcode, key
//  out_chan  out  valid/ready    hit, result_key, result_index, was_present,
//                                store_full
//  cfg       in   cfg_we         cfg_wdata = signed_order
//
//  An item passes in order through accept, compare in every cell (flags
//  registered), then boundary encode, result load and insert shift.
//  A stalled result holds the item in its last step until out_chan takes it.
//  Reset empties the store by clearing the element count only; slot contents
//  are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module sorted_key_set_unit
  import skset_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  skset_in_if.sink    in_chan,
  skset_out_if.source out_chan,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic                 signed_order_r;
  logic [OP_W-1:0]      op_r;
  skey_t                key_r;
  skey_t                cmp_ord;

  logic                 in_fire;
  logic                 exec_fire;
  logic                 do_ins;
  logic                 strict;
  logic                 full;
  logic                 present;

  skey_t     [SLOT_COUNT-1:0] keys;
  logic      [SLOT_COUNT-1:0] lt;
  logic      [SLOT_COUNT-1:0] eq;
  logic      [SLOT_COUNT-1:0] occ;
  logic      [SLOT_COUNT-1:0] below;
  logic      [SLOT_COUNT-1:0] bnd;
  cell_ctl_t [SLOT_COUNT-1:0] ctl;
  enc_res_t                   enc;

  logic                 out_valid_r;
  logic                 hit_r, hit_nxt;
  logic [KEY_W-1:0]     rkey_r, rkey_nxt;
  logic [RIDX_W-1:0]    ridx_r, ridx_nxt;
  logic                 wp_r, wp_nxt;
  logic                 full_r, full_nxt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_order_r <= 1'b0;
    end else if (cfg_we) begin
      signed_order_r <= cfg_wdata;
    end
  end

  // sequencer
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign exec_fire     = (state_r == ST_EXEC) & (~out_valid_r | out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_chan.opcode;
      key_r <= KEY_BITS'(in_chan.key);
    end
  end

  assign cmp_ord = order_key(key_r, signed_order_r);

  // occupancy thermometer from the element count
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      occ[i] = (CNT_W'(i) < count_r);
    end
  end

  assign strict = (op_r == OP_UPPER);

  // leading run of slots below the search key, ends at the first slot that is not
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i == 0) begin
        below[i] = occ[i] & (lt[i] | (strict & eq[i]));
      end else begin
        below[i] = below[i-1] & occ[i] & (lt[i] | (strict & eq[i]));
      end
    end
  end

  // chain of cells
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    skey_t nbr;
    if (g == 0) begin : g_head
      assign nbr = key_r;
    end else begin : g_body
      assign nbr = keys[g-1];
    end
    skset_cell u_cell (
      .clk          (clk),
      .ctl          (ctl[g]),
      .nbr_key      (nbr),
      .new_key      (key_r),
      .cmp_ord      (cmp_ord),
      .signed_order (signed_order_r),
      .key_o        (keys[g]),
      .lt_o         (lt[g]),
      .eq_o         (eq[g])
    );
  end

  skset_enc u_enc (
    .occ   (occ),
    .below (below),
    .eq    (eq),
    .keys  (keys),
    .bnd   (bnd),
    .res   (enc)
  );

  // insert decision and cell control
  assign present = enc.bnd_hit & enc.bnd_eq;
  assign full    = (count_r == CNT_W'(SLOT_COUNT));
  assign do_ins  = exec_fire & (op_r == OP_INSERT) & ~present & ~full;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      ctl[i].load  = do_ins & bnd[i];
      ctl[i].shift = do_ins & ~below[i] & ~bnd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_ins) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // result selection
  always_comb begin
    hit_nxt  = 1'b0;
    rkey_nxt = '0;
    ridx_nxt = '0;
    wp_nxt   = 1'b0;
    full_nxt = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        priority if (present) begin
          hit_nxt  = 1'b1;
          rkey_nxt = KEY_W'(enc.bnd_key);
          ridx_nxt = RIDX_W'(enc.pos);
          wp_nxt   = 1'b1;
        end else if (full) begin
          full_nxt = 1'b1;
        end else begin
          hit_nxt  = 1'b1;
          rkey_nxt = KEY_W'(key_r);
          ridx_nxt = RIDX_W'(enc.pos);
        end
      end
      OP_FIND: begin
        if (present) begin
          hit_nxt  = 1'b1;
          rkey_nxt = KEY_W'(enc.bnd_key);
          ridx_nxt = RIDX_W'(enc.pos);
        end
      end
      OP_LOWER, OP_UPPER: begin
        if (enc.bnd_hit) begin
          hit_nxt  = 1'b1;
          rkey_nxt = KEY_W'(enc.bnd_key);
          ridx_nxt = RIDX_W'(enc.pos);
        end
      end
      OP_FIRST: begin
        if (occ[0]) begin
          hit_nxt  = 1'b1;
          rkey_nxt = KEY_W'(keys[0]);
        end
      end
      OP_LAST: begin
        if (occ[0]) begin
          hit_nxt  = 1'b1;
          rkey_nxt = KEY_W'(enc.last_key);
          ridx_nxt = RIDX_W'(count_r - CNT_W'(1));
        end
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      hit_r  <= hit_nxt;
      rkey_r <= rkey_nxt;
      ridx_r <= ridx_nxt;
      wp_r   <= wp_nxt;
      full_r <= full_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.hit          = hit_r;
  assign out_chan.result_key   = rkey_r;
  assign out_chan.result_index = ridx_r;
  assign out_chan.was_present  = wp_r;
  assign out_chan.store_full   = full_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("element count above slot count");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_CMP)
    else $error("accepted transaction did not enter compare step");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && full_nxt |-> count_r == CNT_W'(SLOT_COUNT))
    else $error("insert refused while slots remain");

  a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> $onehot0(bnd))
    else $error("more than one insertion boundary in chain");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the element count");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted key set unit. A short table of requests
// runs against an empty store first, and most of its answers are typed in.
// Random phases follow under both key orders. They fill the store and then
// keep searching and inserting once it is full. Every reply is compared field
// by field with its typed answer or with a shadow copy of the set kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import skset_pkg::*;

  // unused opcode values, which must return no element
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic [KEY_W-1:0] SIGN_MASK = 1 << (KEY_W - 1);
  localparam int IDLE_PCT   = 24;
  localparam int LONG_HOLD  = 200;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 340;

  typedef struct packed {
    logic              hit;
    logic [KEY_W-1:0]  key;
    logic [RIDX_W-1:0] pos;
    logic              was_present;
    logic              store_full;
  } reply_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic             typed;
    reply_t           reply;
  } stim_row_t;

  localparam reply_t NO_ELEMENT = '0;

  // directed requests, starting from an empty store in unsigned order
  localparam int DIRECTED_ROWS = 21;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_FIRST,   32'h0000_0000, 1'b1, NO_ELEMENT},
    '{OP_LAST,    32'h0000_0000, 1'b1, NO_ELEMENT},
    '{OP_FIND,    32'hFFFF_FFFF, 1'b1, NO_ELEMENT},
    '{OP_LOWER,   32'h0000_0000, 1'b1, NO_ELEMENT},
    '{OP_UPPER,   32'h0000_0000, 1'b1, NO_ELEMENT},
    '{OP_INSERT,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0}},
    '{OP_INSERT,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd0, 1'b0, 1'b0}},
    '{OP_INSERT,  32'h8000_0000, 1'b1, '{1'b1, 32'h8000_0000, 6'd1, 1'b0, 1'b0}},
    '{OP_INSERT,  32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h7FFF_FFFF, 6'd1, 1'b0, 1'b0}},
    '{OP_INSERT,  32'h8000_0000, 1'b1, '{1'b1, 32'h8000_0000, 6'd2, 1'b1, 1'b0}},
    '{OP_FIND,    32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h7FFF_FFFF, 6'd1, 1'b0, 1'b0}},
    '{OP_FIND,    32'h1234_5678, 1'b1, NO_ELEMENT},
    '{OP_LOWER,   32'h1234_5678, 1'b0, NO_ELEMENT},
    '{OP_UPPER,   32'h7FFF_FFFF, 1'b0, NO_ELEMENT},
    '{OP_UPPER,   32'hFFFF_FFFF, 1'b0, NO_ELEMENT},
    '{OP_LOWER,   32'hFFFF_FFFF, 1'b0, NO_ELEMENT},
    '{OP_FIRST,   32'hA5A5_A5A5, 1'b0, NO_ELEMENT},
    '{OP_LAST,    32'h5A5A_5A5A, 1'b0, NO_ELEMENT},
    '{OP_SPARE_A, 32'hFFFF_FFFF, 1'b1, NO_ELEMENT},
    '{OP_SPARE_B, 32'h0F0F_0F0F, 1'b1, NO_ELEMENT},
    '{OP_INSERT,  32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd0, 1'b1, 1'b0}}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  skset_in_if  in_if ();
  skset_out_if out_if ();

  sorted_key_set_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the set and its key order
  skey_t  shadow_keys [SLOT_COUNT];
  int     shadow_count = 0;
  logic   order_signed = 1'b0;

  reply_t pending_replies [$];
  int     error_count = 0;
  bit     calm = 1'b0;
  bit     hold_replies = 1'b0;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // value whose unsigned order is the selected key order
  function automatic skey_t order_rank(input skey_t k);
    return order_signed ? (k ^ SIGN_MASK) : k;
  endfunction

  // first slot not below k, or above k when strict, scanning in slot order
  function automatic int scan_position(input skey_t k, input bit strict);
    int p;
    for (p = 0; p < shadow_count; p++) begin
      if (strict ? (order_rank(shadow_keys[p]) > order_rank(k))
                 : (order_rank(shadow_keys[p]) >= order_rank(k)))
        return p;
    end
    return p;
  endfunction

  // reply to one request, updating the shadow set on insert
  function automatic reply_t apply_request(input logic [OP_W-1:0] op, input skey_t k);
    int     pos;
    bit     found;
    reply_t r;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    case (op)
      OP_INSERT: begin
        pos = scan_position(k, 1'b0);
        if (pos < shadow_count && order_rank(shadow_keys[pos]) == order_rank(k)) begin
          found         = 1'b1;
          r.was_present = 1'b1;
        end else if (shadow_count >= SLOT_COUNT) begin
          r.store_full = 1'b1;
        end else begin
          for (int j = shadow_count; j > pos; j--) shadow_keys[j] = shadow_keys[j-1];
          shadow_keys[pos] = k;
          shadow_count++;
          found = 1'b1;
        end
      end
      OP_FIND: begin
        pos   = scan_position(k, 1'b0);
        found = pos < shadow_count && order_rank(shadow_keys[pos]) == order_rank(k);
      end
      OP_LOWER: begin
        pos   = scan_position(k, 1'b0);
        found = pos < shadow_count;
      end
      OP_UPPER: begin
        pos   = scan_position(k, 1'b1);
        found = pos < shadow_count;
      end
      OP_FIRST: begin
        found = shadow_count > 0;
      end
      OP_LAST: begin
        found = shadow_count > 0;
        pos   = found ? shadow_count - 1 : 0;
      end
      default: ;
    endcase
    if (found) begin
      r.hit = 1'b1;
      r.key = shadow_keys[pos];
      r.pos = pos[RIDX_W-1:0];
    end
    return r;
  endfunction

  // random key, often near keys already stored
  function automatic skey_t pick_key();
    skey_t base;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        if (shadow_count == 0) return skey_t'($urandom());
        base = shadow_keys[$urandom_range(shadow_count - 1)];
        case ($urandom_range(2))
          0: return base;
          1: return base + 1;
          default: return base - 1;
        endcase
      end
      4: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      5: return skey_t'($urandom_range(15));
      6: return SIGN_MASK ^ skey_t'($urandom_range(15));
      default: return skey_t'($urandom());
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 17)      return OP_INSERT;
    else if (r < 34) return OP_FIND;
    else if (r < 51) return OP_LOWER;
    else if (r < 68) return OP_UPPER;
    else if (r < 80) return OP_FIRST;
    else if (r < 92) return OP_LAST;
    else if (r < 96) return OP_SPARE_A;
    else             return OP_SPARE_B;
  endfunction

  // offer one request and wait for the transaction
  task automatic push_item(input logic [OP_W-1:0] op, input skey_t k,
                           input bit typed, input reply_t typed_reply);
    reply_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.key    <= k;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = apply_request(op, k);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // let every outstanding reply return, then leave the unit idle
  task automatic drain_replies();
    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(input logic sgn);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= sgn;
    @(posedge clk);
    cfg_we       <= 1'b0;
    order_signed  = sgn;
  endtask

  // request side
  initial begin
    stim_row_t row;
    in_if.valid  = 1'b0;
    in_if.opcode = '0;
    in_if.key    = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      push_item(row.op, row.key, row.typed, row.reply);
    end

    // random phases, alternating the key order
    for (int ph = 0; ph < PHASES; ph++) begin
      set_order(ph % 2 == 0);
      calm = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 100) hold_replies = 1'b1;
        push_item(pick_op(), pick_key(), 1'b0, NO_ELEMENT);
      end
    end

    // wait for the tail, bounded
    in_if.valid <= 1'b0;
    for (int w = 0; w < 2000 && pending_replies.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_replies.size() != 0)
      flag_error($sformatf("%0d replies never arrived", pending_replies.size()));
    if (error_count == 0) begin
      $display("PASS sorted_key_set_unit");
    end else begin
      $display("FAIL sorted_key_set_unit");
    end
    $finish;
  end

  // reply side: random back-pressure and one long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_replies) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_replies = 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // reply checker
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        flag_error("reply with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (out_if.hit !== want.hit)
          flag_error($sformatf("hit %b, expected %b", out_if.hit, want.hit));
        if (out_if.result_key !== want.key)
          flag_error($sformatf("result_key %h, expected %h", out_if.result_key, want.key));
        if (out_if.result_index !== want.pos)
          flag_error($sformatf("result_index %0d, expected %0d",
                               out_if.result_index, want.pos));
        if (out_if.was_present !== want.was_present)
          flag_error($sformatf("was_present %b, expected %b",
                               out_if.was_present, want.was_present));
        if (out_if.store_full !== want.store_full)
          flag_error($sformatf("store_full %b, expected %b",
                               out_if.store_full, want.store_full));
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL sorted_key_set_unit");
    $finish;
  end

endmodule

// ===== files.f =====
design/skset_pkg.sv
design/skset_in_if.sv
design/skset_out_if.sv
design/skset_cell.sv
design/skset_enc.sv
design/sorted_key_set_unit.sv
verif/testbench.sv
